// ===== rtl/sbrc_pkg.sv =====
// Shared types and constants for the barrier servo ramp controller.
// Depends on nothing; imported by the ramp, scaling and top-level modules.
package sbrc_pkg;

    // Field widths
    localparam int STEP_W  = 8;
    localparam int POS_W   = 12;
    localparam int LEVEL_W = 13;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 2'd2;

    // Reset values of the registers and the position
    localparam logic [STEP_W-1:0] STEP_RESET  = 8'd5;
    localparam logic [POS_W-1:0]  LOWER_RESET = 12'd1000;
    localparam logic [POS_W-1:0]  UPPER_RESET = 12'd2000;

    // PWM scaling: level = floor(width * PWM_WRAP / PERIOD_US).
    // The reciprocal is rounded up; with a 26-bit shift the error stays
    // below the smallest fractional gap for every 12-bit width.
    localparam longint PWM_WRAP   = 39062;
    localparam longint PERIOD_US  = 20000;
    localparam int     PWM_SHIFT  = 26;
    localparam int     RECIP_W    = 27;
    localparam longint PWM_RECIP_L =
        (PWM_WRAP * (longint'(1) << PWM_SHIFT) + PERIOD_US - 1) / PERIOD_US;
    localparam logic [RECIP_W-1:0] PWM_RECIP = RECIP_W'(PWM_RECIP_L);

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE    = 2'd0,
        MODE_MOVING  = 2'd1,
        MODE_BLOCKED = 2'd2
    } t_mode;

    // Barrier state carried from tick to tick
    typedef struct packed {
        t_mode             mode;
        logic [POS_W-1:0]  position;
        logic              moving_up;
    } t_state;

    // One tick as held in the input register
    typedef struct packed {
        logic              command_valid;
        logic [MODE_W-1:0] command_mode;
        logic              command_up;
        logic              safety_valid;
        logic              safety_clear;
    } t_tick;

    // Configuration as seen by the ramp logic
    typedef struct packed {
        logic [STEP_W-1:0] step_size;
        logic [POS_W-1:0]  lower_limit;
        logic [POS_W-1:0]  upper_limit;
    } t_cfg;

endpackage

// ===== rtl/servo_barrier_ramp_controller_unit.sv =====
// Barrier servo ramp controller: input register, state update, PWM scaling.
// Depends on sbrc_pkg, sbrc_ramp and sbrc_pwm.
// After its input transfer, a result passes the state register, then the
// result register after the PWM scaling.
// Throughput: one item per cycle; a stage stalls only when the stage after it
// is full and the output is held.
// Reset: synchronous, active low; mode idle, width 1000, registers at defaults.
module servo_barrier_ramp_controller_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration writes
    input  logic                             i_cfg_wr_en,
    input  logic [sbrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sbrc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Tick input
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_command_valid,
    input  logic [sbrc_pkg::MODE_W-1:0]      i_command_mode,
    input  logic                             i_command_up,
    input  logic                             i_safety_valid,
    input  logic                             i_safety_clear,
    // Result output
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [sbrc_pkg::POS_W-1:0]       o_pulse_width,
    output logic [sbrc_pkg::LEVEL_W-1:0]     o_pwm_level,
    output logic [sbrc_pkg::MODE_W-1:0]      o_mode
);
    import sbrc_pkg::*;

    t_cfg                r_cfg;
    t_state              r_state;
    t_state              n_state;
    t_tick               r_tick;
    logic                r_in_valid;
    logic                r_mid_valid;
    logic [POS_W-1:0]    r_mid_width;
    t_mode               r_mid_mode;
    logic                r_out_valid;
    logic [POS_W-1:0]    r_out_width;
    logic [LEVEL_W-1:0]  r_out_level;
    t_mode               r_out_mode;
    logic [LEVEL_W-1:0]  n_level;
    logic                mid_ready;
    logic                out_ready;

    // Stall chain: each stage advances when the one after it can take data
    assign out_ready = !r_out_valid || i_ready;
    assign mid_ready = !r_mid_valid || out_ready;
    assign o_ready   = !r_in_valid || mid_ready;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size   <= STEP_RESET;
            r_cfg.lower_limit <= LOWER_RESET;
            r_cfg.upper_limit <= UPPER_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_STEP_SIZE:   r_cfg.step_size   <= i_cfg_data[STEP_W-1:0];
                CFG_LOWER_LIMIT: r_cfg.lower_limit <= i_cfg_data[POS_W-1:0];
                CFG_UPPER_LIMIT: r_cfg.upper_limit <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the tick on an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_tick.command_valid <= i_command_valid;
            r_tick.command_mode  <= i_command_mode;
            r_tick.command_up    <= i_command_up;
            r_tick.safety_valid  <= i_safety_valid;
            r_tick.safety_clear  <= i_safety_clear;
        end
    end

    sbrc_ramp u_ramp (
        .i_state (r_state),
        .i_tick  (r_tick),
        .i_cfg   (r_cfg),
        .o_state (n_state)
    );

    // Advance the barrier state and hand width and mode to the scaling stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode      <= MODE_IDLE;
            r_state.position  <= LOWER_RESET;
            r_state.moving_up <= 1'b0;
            r_mid_valid       <= 1'b0;
        end else if (mid_ready) begin
            r_mid_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && mid_ready) begin
            r_mid_width <= n_state.position;
            r_mid_mode  <= n_state.mode;
        end
    end

    sbrc_pwm u_pwm (
        .i_width (r_mid_width),
        .o_level (n_level)
    );

    // Result register; hold while the transfer is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mid_valid && out_ready) begin
            r_out_width <= r_mid_width;
            r_out_level <= n_level;
            r_out_mode  <= r_mid_mode;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pulse_width = r_out_width;
    assign o_pwm_level   = r_out_level;
    assign o_mode        = r_out_mode;

endmodule

// ===== rtl/sbrc_ramp.sv =====
// Next-state logic of the barrier: command decode, ramp step, clamping.
// Depends on sbrc_pkg for the state, tick and configuration structs.
module sbrc_ramp (
    input  sbrc_pkg::t_state i_state,
    input  sbrc_pkg::t_tick  i_tick,
    input  sbrc_pkg::t_cfg   i_cfg,
    output sbrc_pkg::t_state o_state
);
    import sbrc_pkg::*;

    t_mode            cmd_mode;
    t_mode            mode_a;
    logic             up_a;
    logic [POS_W:0]   up_sum;
    logic [POS_W:0]   down_floor;
    logic             hit_upper;
    logic             hit_lower;

    // Decode the commanded mode; the unused code means idle
    always_comb begin
        unique case (i_tick.command_mode)
            MODE_MOVING:  cmd_mode = MODE_MOVING;
            MODE_BLOCKED: cmd_mode = MODE_BLOCKED;
            default:      cmd_mode = MODE_IDLE;
        endcase
    end

    // Apply a command, if any
    assign mode_a = i_tick.command_valid ? cmd_mode : i_state.mode;
    assign up_a   = i_tick.command_valid ? i_tick.command_up : i_state.moving_up;

    // Limit checks: raising reaches the upper limit when pos + step >= upper,
    // lowering reaches the lower limit when pos <= lower + step
    assign up_sum     = {1'b0, i_state.position} + {5'b0, i_cfg.step_size};
    assign down_floor = {1'b0, i_cfg.lower_limit} + {5'b0, i_cfg.step_size};
    assign hit_upper  = up_sum >= {1'b0, i_cfg.upper_limit};
    assign hit_lower  = {1'b0, i_state.position} <= down_floor;

    // Step, clamp and change mode
    always_comb begin
        o_state.mode      = mode_a;
        o_state.position  = i_state.position;
        o_state.moving_up = up_a;
        case (mode_a)
            MODE_MOVING: begin
                if (up_a) begin
                    if (hit_upper) begin
                        o_state.position = i_cfg.upper_limit;
                        o_state.mode     = MODE_BLOCKED;
                    end else begin
                        o_state.position = up_sum[POS_W-1:0];
                    end
                end else begin
                    if (hit_lower) begin
                        o_state.position = i_cfg.lower_limit;
                        o_state.mode     = MODE_IDLE;
                    end else begin
                        o_state.position = i_state.position - {4'b0, i_cfg.step_size};
                    end
                end
            end
            MODE_BLOCKED: begin
                // Path clear releases the barrier downward, unless a command came
                if (!i_tick.command_valid && i_tick.safety_valid && i_tick.safety_clear) begin
                    o_state.mode      = MODE_MOVING;
                    o_state.moving_up = 1'b0;
                end
            end
            default: begin
                o_state.mode = mode_a;
            end
        endcase
    end

endmodule

// ===== rtl/sbrc_pwm.sv =====
// PWM compare level from the pulse width by reciprocal multiplication.
// Depends on sbrc_pkg for widths and the scaling constant.
module sbrc_pwm (
    input  logic [sbrc_pkg::POS_W-1:0]   i_width,
    output logic [sbrc_pkg::LEVEL_W-1:0] o_level
);
    import sbrc_pkg::*;

    logic [POS_W+RECIP_W-1:0] prod;

    // Scale by the rounded-up reciprocal and drop the fraction
    assign prod    = {{RECIP_W{1'b0}}, i_width} * {{POS_W{1'b0}}, PWM_RECIP};
    assign o_level = prod[PWM_SHIFT +: LEVEL_W];

endmodule
